>>> rtl/rmq_pkg.sv
// Shared types and codes for the rotation-matrix-to-quaternion block.
// No dependencies; imported by rotation_matrix_to_quaternion.
package rmq_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NEG  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   // Quaternion component index, in selection order
   typedef enum logic [1:0] {
      AX_X = 2'd0,
      AX_Y = 2'd1,
      AX_Z = 2'd2,
      AX_W = 2'd3
   } axis_type;

endpackage

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (largest-term method), fully pipelined.
// The pipeline has 3 + RW + QW register stages, RW = root bits, QW = DATA_WIDTH+1+FRAC_BITS
// (50 at the defaults);
// the root and divider stages set the depth.
// Throughput: one item per cycle; the whole pipeline holds while a finished item
// waits on a stalled output. Reset clears the valid bits only.
// Uses rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe.
module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_m00,
   input  logic signed [DATA_WIDTH-1:0]  req_m01,
   input  logic signed [DATA_WIDTH-1:0]  req_m02,
   input  logic signed [DATA_WIDTH-1:0]  req_m10,
   input  logic signed [DATA_WIDTH-1:0]  req_m11,
   input  logic signed [DATA_WIDTH-1:0]  req_m12,
   input  logic signed [DATA_WIDTH-1:0]  req_m20,
   input  logic signed [DATA_WIDTH-1:0]  req_m21,
   input  logic signed [DATA_WIDTH-1:0]  req_m22,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_w,
   output rmq_pkg::status_type           rsp_status
);
   import rmq_pkg::*;

   localparam int OW   = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
   localparam int TW   = OW + 3;
   localparam int NR   = TW - 1 + FRAC_BITS;
   localparam int RW   = (NR + 1) / 2;
   localparam int SQW  = 2 * RW;
   localparam int VW   = RW - 1;
   localparam int DENW = RW + 1;
   localparam int NW   = DATA_WIDTH + 1;
   localparam int QW   = NW + FRAC_BITS;
   localparam int CW   = (VW > DATA_WIDTH) ? VW : DATA_WIDTH;
   localparam int SSW  = 4 + 3 * NW;
   localparam int DSW  = 5 + VW;

   localparam logic signed [TW-1:0] ONE =
      signed'({{(TW-1){1'b0}}, 1'b1} << FRAC_BITS);
   localparam logic [QW-1:0] QMAX = {{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [CW-1:0] VMAX = {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic en;
   logic rsp_valid_ff;

   // Advance everything unless a finished item waits on a stalled output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---- Stage 0: trace terms and off-diagonal sums and differences ----
   logic signed [TW-1:0] t_ff [0:3];
   logic signed [NW-1:0] n_ff [0:5];
   logic                 s0_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= TW'(req_m00) - TW'(req_m11) - TW'(req_m22) + ONE;
         t_ff[1] <= -TW'(req_m00) + TW'(req_m11) - TW'(req_m22) + ONE;
         t_ff[2] <= -TW'(req_m00) - TW'(req_m11) + TW'(req_m22) + ONE;
         t_ff[3] <= TW'(req_m00) + TW'(req_m11) + TW'(req_m22) + ONE;
         n_ff[0] <= NW'(req_m01) + NW'(req_m10);
         n_ff[1] <= NW'(req_m20) + NW'(req_m02);
         n_ff[2] <= NW'(req_m12) + NW'(req_m21);
         n_ff[3] <= NW'(req_m12) - NW'(req_m21);
         n_ff[4] <= NW'(req_m20) - NW'(req_m02);
         n_ff[5] <= NW'(req_m01) - NW'(req_m10);
      end
   end

   // ---- Stage 1: pick the largest term, route numerators ----
   axis_type             best_in, best_ff;
   status_type           stat_in, stat_ff;
   logic signed [TW-1:0] tb;
   logic [SQW-1:0]       rad_in, rad_ff;
   logic signed [NW-1:0] num_in [0:2];
   logic signed [NW-1:0] num_ff [0:2];
   logic                 s1_vld_ff;

   always_comb begin
      best_in = AX_X;
      tb      = t_ff[0];
      if (t_ff[1] > tb) begin
         best_in = AX_Y;
         tb      = t_ff[1];
      end
      if (t_ff[2] > tb) begin
         best_in = AX_Z;
         tb      = t_ff[2];
      end
      if (t_ff[3] > tb) begin
         best_in = AX_W;
         tb      = t_ff[3];
      end
      priority if (tb[TW-1]) begin
         stat_in = ST_NEG;
      end else if (tb == '0) begin
         stat_in = ST_ZERO;
      end else begin
         stat_in = ST_OK;
      end
      rad_in = (stat_in == ST_OK) ? (SQW'(tb[TW-2:0]) << FRAC_BITS) : '0;
      unique case (best_in)
         AX_X: begin
            num_in[0] = n_ff[0]; num_in[1] = n_ff[1]; num_in[2] = n_ff[3];
         end
         AX_Y: begin
            num_in[0] = n_ff[0]; num_in[1] = n_ff[2]; num_in[2] = n_ff[4];
         end
         AX_Z: begin
            num_in[0] = n_ff[1]; num_in[1] = n_ff[2]; num_in[2] = n_ff[5];
         end
         default: begin
            num_in[0] = n_ff[3]; num_in[1] = n_ff[4]; num_in[2] = n_ff[5];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         best_ff <= best_in;
         stat_ff <= stat_in;
         rad_ff  <= rad_in;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= num_in[i];
         end
      end
   end

   // ---- Square root of the chosen term ----
   logic            sq_vld;
   logic [RW-1:0]   sq_root;
   logic [SSW-1:0]  sq_side;

   rmq_sqrt_pipe #(.W(SQW), .SW(SSW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_vld_ff),
      .in_rad    (rad_ff),
      .in_side   ({best_ff, stat_ff, num_ff[0], num_ff[1], num_ff[2]}),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---- Three divisions by four times the halved root ----
   logic [VW-1:0]   v;
   logic [DENW-1:0] den;
   logic [NW-1:0]   sq_num [0:2];
   logic [DSW-1:0]  dv_side0;
   logic [QW-1:0]   quot [0:2];
   logic            neg_out [0:2];
   logic            dv_vld;

   assign v   = sq_root[RW-1:1];
   assign den = {v, 2'b00};
   assign sq_num[0] = sq_side[3*NW-1:2*NW];
   assign sq_num[1] = sq_side[2*NW-1:NW];
   assign sq_num[2] = sq_side[NW-1:0];

   for (genvar j = 0; j < 3; j++) begin : g_lane
      logic          neg;
      logic [NW-1:0] mag;
      logic [QW-1:0] dividend;

      assign neg      = sq_num[j][NW-1];
      assign mag      = neg ? NW'(-sq_num[j]) : sq_num[j];
      assign dividend = {mag, {FRAC_BITS{1'b0}}};

      if (j == 0) begin : g_main
         rmq_div_pipe #(.QW(QW), .DW(DENW), .SW(DSW)) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (sq_vld),
            .in_num    (dividend),
            .in_den    (den),
            .in_side   ({sq_side[SSW-1:SSW-4], v, neg}),
            .out_valid (dv_vld),
            .out_quot  (quot[j]),
            .out_side  (dv_side0)
         );
         assign neg_out[j] = dv_side0[0];
      end else begin : g_aux
         logic vld_unused;
         logic side_out;
         rmq_div_pipe #(.QW(QW), .DW(DENW), .SW(1)) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (sq_vld),
            .in_num    (dividend),
            .in_den    (den),
            .in_side   (neg),
            .out_valid (vld_unused),
            .out_quot  (quot[j]),
            .out_side  (side_out)
         );
         assign neg_out[j] = side_out & vld_unused | side_out & !vld_unused;
      end
   end

   // ---- Output stage: saturate and place components ----
   axis_type                 f_best;
   status_type               f_stat;
   logic [VW-1:0]            f_v;
   logic [CW-1:0]            vx;
   logic [DATA_WIDTH-1:0]    v_sat;
   logic [DATA_WIDTH-1:0]    lane_sat [0:2];
   logic [DATA_WIDTH-1:0]    comp_in  [0:3];
   logic [DATA_WIDTH-1:0]    comp_ff  [0:3];
   status_type               rsp_status_ff;

   assign f_best = axis_type'(dv_side0[DSW-1:DSW-2]);
   assign f_stat = status_type'(dv_side0[DSW-3:DSW-4]);
   assign f_v    = dv_side0[VW:1];
   assign vx     = CW'(f_v);
   assign v_sat  = (vx > VMAX) ? DMAX : vx[DATA_WIDTH-1:0];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (!neg_out[j]) begin
            lane_sat[j] = (quot[j] > QMAX) ? DMAX : quot[j][DATA_WIDTH-1:0];
         end else begin
            lane_sat[j] = (quot[j] > QMAX + QW'(1)) ? DMIN :
                          DATA_WIDTH'(-quot[j][DATA_WIDTH-1:0]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (f_stat != ST_OK) begin
            comp_in[c] = '0;
         end else if (c == int'(f_best)) begin
            comp_in[c] = v_sat;
         end else if (c < int'(f_best)) begin
            comp_in[c] = lane_sat[c];
         end else begin
            comp_in[c] = lane_sat[c-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            comp_ff[c] <= comp_in[c];
         end
         rsp_status_ff <= f_stat;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = signed'(comp_ff[0]);
   assign rsp_quat_y = signed'(comp_ff[1]);
   assign rsp_quat_z = signed'(comp_ff[2]);
   assign rsp_quat_w = signed'(comp_ff[3]);
   assign rsp_status = rsp_status_ff;

   // ---- Checks ----
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_quat_x == '0) && (rsp_quat_y == '0) && (rsp_quat_z == '0) &&
         (rsp_quat_w == '0))
      else $error("non-ok status with nonzero components");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled output item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("status code out of range");

endmodule

>>> rtl/rmq_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side vector alongside each item. Depends on nothing.
module rmq_sqrt_pipe #(
   parameter int W  = 32,
   parameter int SW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [W-1:0]    in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [W/2-1:0]  out_root,
   output logic [SW-1:0]   out_side
);
   localparam int N = W / 2;

   logic [W:0]    x_ff    [0:N-1];
   logic [W:0]    res_ff  [0:N-1];
   logic [SW-1:0] side_ff [0:N-1];
   logic [N-1:0]  vld_ff;

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [W:0] BIT_K = {{W{1'b0}}, 1'b1} << (W - 2 - 2 * k);
      logic [W:0]    x_cur, res_cur, x_in, res_in, trial;
      logic [SW-1:0] side_cur;
      logic          vld_cur;

      if (k == 0) begin : g_first
         assign x_cur    = {1'b0, in_rad};
         assign res_cur  = '0;
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign x_cur    = x_ff[k-1];
         assign res_cur  = res_ff[k-1];
         assign side_cur = side_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
      end

      // Try the next bit of the root
      always_comb begin
         trial = res_cur + BIT_K;
         if (x_cur >= trial) begin
            x_in   = x_cur - trial;
            res_in = (res_cur >> 1) + BIT_K;
         end else begin
            x_in   = x_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = res_ff[N-1][N-1:0];
   assign out_side  = side_ff[N-1];

endmodule

>>> rtl/rmq_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Carries a side vector alongside each item. Depends on nothing.
module rmq_div_pipe #(
   parameter int QW = 31,
   parameter int DW = 17,
   parameter int SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [QW-1:0]  in_num,
   input  logic [DW-1:0]  in_den,
   input  logic [SW-1:0]  in_side,
   output logic           out_valid,
   output logic [QW-1:0]  out_quot,
   output logic [SW-1:0]  out_side
);
   logic [DW-1:0] rem_ff  [0:QW-1];
   logic [QW-1:0] dq_ff   [0:QW-1];
   logic [DW-1:0] den_ff  [0:QW-1];
   logic [SW-1:0] side_ff [0:QW-1];
   logic [QW-1:0] vld_ff;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_cur, den_cur, rem_in;
      logic [QW-1:0] dq_cur, dq_in;
      logic [DW:0]   trial;
      logic [SW-1:0] side_cur;
      logic          vld_cur, ge;

      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign dq_cur   = in_num;
         assign den_cur  = in_den;
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign dq_cur   = dq_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign side_cur = side_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
      end

      // Shift in one dividend bit and subtract where it fits
      always_comb begin
         trial  = {rem_cur, dq_cur[QW-1]};
         ge     = (trial >= {1'b0, den_cur});
         rem_in = ge ? DW'(trial - {1'b0, den_cur}) : trial[DW-1:0];
         dq_in  = {dq_cur[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            dq_ff[k]   <= dq_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = dq_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
